// ===== hdl/tdpt_pkg.sv =====
// Package for the trial-division prime tester: widths, microcode fields and the control ROM.
package tdpt_pkg;

  // Default operand width
  localparam int NumberBitsDef = 20;

  // Program counter width and step addresses
  localparam int PcW = 4;
  localparam logic [PcW-1:0] S_IDLE    = 4'd0;
  localparam logic [PcW-1:0] S_LT2     = 4'd1;
  localparam logic [PcW-1:0] S_EQ2     = 4'd2;
  localparam logic [PcW-1:0] S_EVEN    = 4'd3;
  localparam logic [PcW-1:0] S_LOOP    = 4'd4;
  localparam logic [PcW-1:0] S_DIVSTEP = 4'd5;
  localparam logic [PcW-1:0] S_CHKREM  = 4'd6;
  localparam logic [PcW-1:0] S_BACK    = 4'd7;
  localparam logic [PcW-1:0] S_REP0    = 4'd8;
  localparam logic [PcW-1:0] S_REP1    = 4'd9;

  // Datapath operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_DINIT  = 3'd2;
  localparam logic [2:0] OP_DSTEP  = 3'd3;
  localparam logic [2:0] OP_NEXTD  = 3'd4;
  localparam logic [2:0] OP_REPORT = 3'd5;

  // Jump conditions
  localparam logic [3:0] C_NEXT   = 4'd0;  // never jump, fall through
  localparam logic [3:0] C_ALWAYS = 4'd1;
  localparam logic [3:0] C_NOSTRT = 4'd2;  // no start request
  localparam logic [3:0] C_LT2    = 4'd3;
  localparam logic [3:0] C_EQ2    = 4'd4;
  localparam logic [3:0] C_EVEN   = 4'd5;
  localparam logic [3:0] C_SQGT   = 4'd6;  // divisor squared exceeds number
  localparam logic [3:0] C_MORE   = 4'd7;  // more remainder steps to go
  localparam logic [3:0] C_RZERO  = 4'd8;  // remainder is zero

  // One control word
  typedef struct packed {
    logic [2:0]     op;
    logic [3:0]     cond;
    logic [PcW-1:0] target;
    logic           prime;
  } ctrl_t;

  // Control program
  function automatic ctrl_t ucode_rom(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE, prime: 1'b0};
    unique case (pc)
      S_IDLE:    w = '{op: OP_LOAD,   cond: C_NOSTRT, target: S_IDLE,    prime: 1'b0};
      S_LT2:     w = '{op: OP_NONE,   cond: C_LT2,    target: S_REP0,    prime: 1'b0};
      S_EQ2:     w = '{op: OP_NONE,   cond: C_EQ2,    target: S_REP1,    prime: 1'b0};
      S_EVEN:    w = '{op: OP_NONE,   cond: C_EVEN,   target: S_REP0,    prime: 1'b0};
      S_LOOP:    w = '{op: OP_DINIT,  cond: C_SQGT,   target: S_REP1,    prime: 1'b0};
      S_DIVSTEP: w = '{op: OP_DSTEP,  cond: C_MORE,   target: S_DIVSTEP, prime: 1'b0};
      S_CHKREM:  w = '{op: OP_NEXTD,  cond: C_RZERO,  target: S_REP0,    prime: 1'b0};
      S_BACK:    w = '{op: OP_NONE,   cond: C_ALWAYS, target: S_LOOP,    prime: 1'b0};
      S_REP0:    w = '{op: OP_REPORT, cond: C_ALWAYS, target: S_IDLE,    prime: 1'b0};
      S_REP1:    w = '{op: OP_REPORT, cond: C_ALWAYS, target: S_IDLE,    prime: 1'b1};
      default:   w = '{op: OP_NONE,   cond: C_ALWAYS, target: S_IDLE,    prime: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/trial_division_prime_test.sv =====
// Top level of the trial-division prime tester: microcoded sequencer and its datapath.
//
//   channel   ports                    handshake
//   -------   ----------------------   --------------------------------------
//   input     in_number                taken when start is high and busy low
//   result    out_prime                shown one cycle while out_valid is high
//
// Each odd trial divisor tried (up to ~512 for 20 bits) runs the remainder loop
// over all NUMBER_BITS bits; zero, one, two and even numbers skip the loop. The
// bit-serial remainder unit takes one quotient bit per cycle. busy is high from
// the cycle after acceptance until the result step; out_valid follows in the
// next cycle, with busy already low.
// Reset (rst_n, synchronous, active low) returns the program counter to idle.
// The receiver cannot stall the result.
module trial_division_prime_test #(
  parameter int NUMBER_BITS = tdpt_pkg::NumberBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [NUMBER_BITS-1:0] in_number,
  output logic                   out_valid,
  output logic                   out_prime
);
  import tdpt_pkg::*;

  localparam int NB   = NUMBER_BITS;
  localparam int CntW = $clog2(NB + 1);
  localparam int SqW  = NB + 2;

  // Sequencer state
  logic [PcW-1:0]  pc_r, pc_nxt;
  ctrl_t           cw;
  logic            jump;

  // Datapath registers
  logic [NB-1:0]   n_r, n_nxt;
  logic [NB-1:0]   d_r, d_nxt;
  logic [SqW-1:0]  sq_r, sq_nxt;
  logic [NB-1:0]   rem_r, rem_nxt;
  logic [NB-1:0]   sh_r, sh_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_prime_r, out_prime_nxt;

  // Remainder step
  logic [NB:0]     shifted;
  logic [NB-1:0]   diff;

  // Fetch the control word
  assign cw = ucode_rom(pc_r);

  // Evaluate the jump condition
  always_comb begin
    unique case (cw.cond)
      C_NEXT:   jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_NOSTRT: jump = !start;
      C_LT2:    jump = (n_r < NB'(2));
      C_EQ2:    jump = (n_r == NB'(2));
      C_EVEN:   jump = !n_r[0];
      C_SQGT:   jump = (sq_r > {2'b00, n_r});
      C_MORE:   jump = (cnt_r > CntW'(1));
      C_RZERO:  jump = (rem_r == '0);
      default:  jump = 1'b0;
    endcase
  end

  // Advance the step counter
  assign pc_nxt = jump ? cw.target : pc_r + PcW'(1);

  // The difference is below the divisor whenever it is taken, so NB bits hold it
  assign shifted = {rem_r, sh_r[NB-1]};
  assign diff    = shifted[NB-1:0] - d_r;

  // Run the datapath operation
  always_comb begin
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_prime_nxt = out_prime_r;
    unique case (cw.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        n_nxt  = in_number;
        d_nxt  = NB'(3);
        sq_nxt = SqW'(9);
      end
      OP_DINIT: begin
        rem_nxt = '0;
        sh_nxt  = n_r;
        cnt_nxt = CntW'(NB);
      end
      OP_DSTEP: begin
        rem_nxt = (shifted >= {1'b0, d_r}) ? diff : shifted[NB-1:0];
        sh_nxt  = {sh_r[NB-2:0], 1'b0};
        cnt_nxt = cnt_r - CntW'(1);
      end
      OP_NEXTD: begin
        // (d+2)^2 = d^2 + 4d + 4
        d_nxt  = d_r + NB'(2);
        sq_nxt = sq_r + {d_r, 2'b00} + SqW'(4);
      end
      OP_REPORT: begin
        out_valid_nxt = 1'b1;
        out_prime_nxt = cw.prime;
      end
      default: begin
      end
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Update payload registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    sh_r        <= sh_nxt;
    cnt_r       <= cnt_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign busy      = (pc_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_prime = out_prime_r;

  // A result appears only once the sequencer is back at idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pc_r == S_IDLE))
    else $error("result shown while sequencer busy");

  // An accepted word always starts a test
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start a test");

  // Only two or odd numbers can be reported prime
  a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_prime_r) |-> (n_r[0] || (n_r == NB'(2))))
    else $error("even number other than two reported prime");

  // The remainder loop never runs past its bit count
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_DIVSTEP) |-> (cnt_r != '0))
    else $error("remainder step with exhausted bit count");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the trial-division prime tester: directed and random numbers against a scoreboard.
module tb;
  import tdpt_pkg::*;

  localparam int NB = NumberBitsDef;
  localparam longint unsigned NUM_MAX = (64'd1 << NB) - 1;
  localparam int HALF_PERIOD = 10;
  localparam int RANDOM_WORDS = 75;
  localparam int MAX_GAP = 18;
  // Quiet cycles after the last result; no word can cause a late result.
  localparam int SETTLE_CYCLES = 64;

  // Hold expected verdicts in order of acceptance and compare each result word.
  class prime_scoreboard;
    bit verdicts_due[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned numbers_seen;
    int unsigned primes_seen;

    // Decide primality by odd trial divisors while divisor squared fits in n.
    static function bit prime_verdict(longint unsigned n);
      longint unsigned d;
      if (n < 2) return 1'b0;
      if (n == 2) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = 3; d * d <= n; d += 2) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_number(logic [NB-1:0] n);
      bit verdict;
      verdict = prime_verdict(longint'(n));
      verdicts_due.push_back(verdict);
      numbers_seen++;
      if (verdict) primes_seen++;
    endfunction

    function void check_verdict(logic actual);
      bit want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: result word with nothing pending: expected none, actual prime=%b",
                 $time, actual);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      checked++;
      if (actual !== want) begin
        $display("%0t: prime flag mismatch: expected %b, actual %b", $time, want, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [NB-1:0] in_number;
  logic out_valid;
  logic out_prime;

  prime_scoreboard sb;

  trial_division_prime_test #(.NUMBER_BITS(NB)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_number(in_number),
    .out_valid(out_valid),
    .out_prime(out_prime)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Check every result word at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_verdict(out_prime);
  end

  // Return the first prime at or above from.
  function automatic longint unsigned next_prime(longint unsigned from);
    longint unsigned p;
    p = (from < 3) ? 2 : (from | 1);
    while (!prime_scoreboard::prime_verdict(p)) p += (p == 2) ? 1 : 2;
    return p;
  endfunction

  // Draw one number: mostly small, some full range, a few that run the whole loop.
  function automatic logic [NB-1:0] draw_number();
    int unsigned pick;
    longint unsigned a;
    longint unsigned b;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      return NB'($urandom_range(0, (1 << $urandom_range(2, 12)) - 1));
    end else if (pick < 8) begin
      return NB'($urandom_range(0, int'(NUM_MAX)));
    end else if (pick == 8) begin
      // large prime: every divisor up to the root is tried
      return NB'(next_prime($urandom_range(int'(NUM_MAX >> 1), int'(NUM_MAX - 600))));
    end
    // product of two large primes: the factor shows up only near the root
    a = next_prime($urandom_range(500, 1000));
    b = next_prime(a + 1);
    if (a * b > NUM_MAX) b = a;
    return NB'(a * b);
  endfunction

  // Wait gap cycles with start low, then offer n until the block takes it.
  task automatic send_number(logic [NB-1:0] n, int unsigned gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_number = n;
    do @(posedge clk); while (busy);
    sb.note_number(n);
    @(negedge clk);
  endtask

  logic [NB-1:0] directed_numbers[] = '{
    0, 1, 2, 3, 4, 5, 7, 9, 11, 15, 25, 49, 97, 121, 1023, 1024, 65521,
    524287, 524288, 999983, 1018081, 1022117, 1042441, 1048573, 1048574, 1048575
  };

  initial begin
    bit steady;
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_number = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Extremes, small special cases, squares of primes and the largest primes.
    foreach (directed_numbers[i]) begin
      send_number(directed_numbers[i], $urandom_range(0, MAX_GAP));
    end

    // Random numbers; some stretches of 20 words run back to back.
    steady = 1'b0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 20 == 0) steady = ($urandom_range(0, 2) == 0);
      send_number(draw_number(), steady ? 0 : $urandom_range(0, MAX_GAP));
    end
    start = 1'b0;

    // Drain pending verdicts, then hold for stray results.
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d numbers accepted, %0d of them prime, %0d verdicts compared",
             sb.numbers_seen, sb.primes_seen, sb.checked);
    $display("tb: %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.verdicts_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal finish.
  initial begin
    #130_000_000;
    $display("tb: timeout with %0d verdicts pending", sb.verdicts_due.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule
